// ----- rtl/spm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and saturating arithmetic helpers for the servo position model.
package spm_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic signed [32:0] t_mop;
    typedef logic signed [65:0] t_prod;

    typedef struct packed {
        logic en;
        t_mop a;
        t_mop b;
    } t_mul_req;

    localparam logic [2:0] CFG_CENTER    = 3'd0;
    localparam logic [2:0] CFG_HALF      = 3'd1;
    localparam logic [2:0] CFG_INV_HALF  = 3'd2;
    localparam logic [2:0] CFG_GAIN      = 3'd3;
    localparam logic [2:0] CFG_OFFSET    = 3'd4;
    localparam logic [2:0] CFG_DT        = 3'd5;
    localparam logic [2:0] CFG_INV_DT    = 3'd6;
    localparam logic [2:0] CFG_DELAY     = 3'd7;

    localparam t_q K_P   = 32'sd41999612;
    localparam t_q K_D   = 32'sd2239959;
    localparam t_q U_SAT = 32'sd10579949;
    localparam t_q V_SAT = 32'sd452239;

    localparam logic [18:0] CUR_MAX   = 19'd458752;
    localparam int          CUR_SHIFT = 36;
    localparam logic [31:0] CUR_RECIP = 32'((64'd458752 << CUR_SHIFT) / 64'd10579949);

    function automatic t_q qsat(input t_prod p);
        logic signed [49:0] s;
        s = p[65:16];
        if (s > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (s < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    function automatic t_q sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_q clamp33(input logic signed [32:0] v, input t_q lim);
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        hi = {lim[31], lim};
        lo = -hi;
        if (v > hi) begin
            return lim;
        end else if (v < lo) begin
            return -lim;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [32:0] add33(input t_q a, input t_q b);
        return $signed({a[31], a}) + $signed({b[31], b});
    endfunction

    function automatic logic signed [32:0] sub33(input t_q a, input t_q b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

endpackage

// ----- rtl/spm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module spm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spm_mul.sv -----
`timescale 1ns / 1ps
// Shared signed 33 by 33 bit multiplier with a registered product.
module spm_mul (
    input  logic              i_clk,
    input  spm_pkg::t_mul_req i_req,
    output spm_pkg::t_prod    o_prod
);

    spm_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/servo_pid_position_model_unit.sv -----
`timescale 1ns / 1ps
// Top level of the servo position model: register file, delay line, sequencer and output beat.
//
// One input beat carries a command (tuser 0) or a set-position request (tuser 1) and yields
// exactly one output beat. A command beat runs through every sequencer state from NCUR to
// OFS before it reaches the output register and a set-position beat only through OFS, since
// every product in the control law, the plant update and the supply current estimate goes one
// after another through a single shared multiplier with a registered product. The input is
// ready again once the output register is loaded; a beat waits in OUT while a full output
// register drains. The command delay line sits in a RAM of DELAY_DEPTH entries with a
// registered read; the newest command is forwarded when the delay, limited to the commands
// held so far, is zero. The input is taken only while the sequencer is idle, and a finished
// beat waits in the output register, so the next input is accepted while it is still pending.
module servo_pid_position_model_unit #(
    parameter int DELAY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] position
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] actual_position, [50:32] supply_current
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam int CW = (FW > 4) ? FW : 4;
    localparam int CUR_SHIFT_HI = spm_pkg::CUR_SHIFT + 18;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_NCUR   = 5'd1;
    localparam logic [4:0] ST_NCMD   = 5'd2;
    localparam logic [4:0] ST_ERR    = 5'd3;
    localparam logic [4:0] ST_PTERM  = 5'd4;
    localparam logic [4:0] ST_DTERM1 = 5'd5;
    localparam logic [4:0] ST_DTERM2 = 5'd6;
    localparam logic [4:0] ST_DRIVE  = 5'd7;
    localparam logic [4:0] ST_GAIN   = 5'd8;
    localparam logic [4:0] ST_GDT    = 5'd9;
    localparam logic [4:0] ST_VEL    = 5'd10;
    localparam logic [4:0] ST_QEST   = 5'd11;
    localparam logic [4:0] ST_POSN   = 5'd12;
    localparam logic [4:0] ST_QCHK   = 5'd13;
    localparam logic [4:0] ST_POS    = 5'd14;
    localparam logic [4:0] ST_OFS    = 5'd15;
    localparam logic [4:0] ST_OUT    = 5'd16;

    spm_pkg::t_q  r_center;
    logic [30:0]  r_half;
    logic [30:0]  r_inv_half;
    spm_pkg::t_q  r_gain;
    spm_pkg::t_q  r_offset;
    logic [30:0]  r_dt;
    logic [30:0]  r_inv_dt;
    logic [3:0]   r_delay;

    logic [4:0]   r_state;
    logic [4:0]   n_state;
    spm_pkg::t_q  r_pos;
    spm_pkg::t_q  r_vel;
    spm_pkg::t_q  r_prev;
    spm_pkg::t_q  r_cmd;
    spm_pkg::t_q  r_curn;
    spm_pkg::t_q  r_err;
    spm_pkg::t_q  r_diff;
    spm_pkg::t_q  r_p;
    spm_pkg::t_q  r_u;
    logic [23:0]  r_mag;
    logic [18:0]  r_q;
    logic [18:0]  r_cur;
    logic [AW-1:0] r_wi;
    logic [FW-1:0] r_fill;
    logic          r_fwd;

    logic          r_out_valid;
    spm_pkg::t_q   r_out_pos;
    logic [18:0]   r_out_cur;

    logic                 in_fire;
    logic                 out_load;
    logic [FW-1:0]        fill_new;
    logic [FW-1:0]        fill_m1;
    logic [CW-1:0]        idx_c;
    logic [AW-1:0]        idx_a;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        wi_new;
    logic [31:0]          ram_rdata;
    spm_pkg::t_q          cmd_sel;
    spm_pkg::t_mul_req    mul_req;
    spm_pkg::t_prod       prod;
    spm_pkg::t_q          prod_q;
    logic [43:0]          num;
    logic [43:0]          rem;

    spm_ram #(
        .WIDTH (32),
        .DEPTH (DELAY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_fire && !s_axis_tuser[0]),
        .i_waddr (r_wi),
        .i_wdata (s_axis_tdata),
        .i_re    (in_fire && !s_axis_tuser[0]),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    spm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_cur, r_out_pos};

    assign prod_q  = spm_pkg::qsat(prod);
    assign cmd_sel = r_fwd ? r_cmd : $signed(ram_rdata);
    assign num     = (44'(r_mag) << 19) - (44'(r_mag) << 16);
    assign rem     = num - prod[43:0];

    always_comb begin
        fill_new = (r_fill == FW'(DELAY_DEPTH)) ? r_fill : r_fill + 1'b1;
        fill_m1  = fill_new - 1'b1;
        idx_c    = (CW'(r_delay) > CW'(fill_m1)) ? CW'(fill_m1) : CW'(r_delay);
        idx_a    = idx_c[AW-1:0];
        if (r_wi >= idx_a) begin
            raddr = r_wi - idx_a;
        end else begin
            raddr = AW'({1'b0, r_wi} + (AW + 1)'(DELAY_DEPTH) - {1'b0, idx_a});
        end
        if (({1'b0, r_wi} + 1'b1) == (AW + 1)'(DELAY_DEPTH)) begin
            wi_new = '0;
        end else begin
            wi_new = r_wi + 1'b1;
        end
    end

    always_comb begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        unique case (r_state)
            ST_NCUR: begin
                mul_req.a = spm_pkg::sub33(r_pos, r_center);
                mul_req.b = {2'b00, r_inv_half};
            end
            ST_NCMD: begin
                mul_req.a = spm_pkg::sub33(cmd_sel, r_center);
                mul_req.b = {2'b00, r_inv_half};
            end
            ST_PTERM: begin
                mul_req.a = {spm_pkg::K_P[31], spm_pkg::K_P};
                mul_req.b = {r_err[31], r_err};
            end
            ST_DTERM1: begin
                mul_req.a = {spm_pkg::K_D[31], spm_pkg::K_D};
                mul_req.b = {r_diff[31], r_diff};
            end
            ST_DTERM2: begin
                mul_req.a = {prod_q[31], prod_q};
                mul_req.b = {2'b00, r_inv_dt};
            end
            ST_GAIN: begin
                mul_req.a = {r_u[31], r_u};
                mul_req.b = {r_gain[31], r_gain};
            end
            ST_GDT: begin
                mul_req.a = {prod_q[31], prod_q};
                mul_req.b = {2'b00, r_dt};
            end
            ST_VEL: begin
                mul_req.a = {9'd0, r_mag};
                mul_req.b = {1'b0, spm_pkg::CUR_RECIP};
            end
            ST_QEST: begin
                mul_req.a = {r_vel[31], r_vel};
                mul_req.b = {2'b00, r_dt};
            end
            ST_POSN: begin
                mul_req.a = {14'd0, r_q};
                mul_req.b = {spm_pkg::U_SAT[31], spm_pkg::U_SAT};
            end
            ST_QCHK: begin
                mul_req.a = {r_curn[31], r_curn};
                mul_req.b = {2'b00, r_half};
            end
            ST_OFS: begin
                mul_req.a = {r_offset[31], r_offset};
                mul_req.b = {2'b00, r_half};
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = s_axis_tuser[0] ? ST_OFS : ST_NCUR;
                end
            end
            ST_NCUR:   n_state = ST_NCMD;
            ST_NCMD:   n_state = ST_ERR;
            ST_ERR:    n_state = ST_PTERM;
            ST_PTERM:  n_state = ST_DTERM1;
            ST_DTERM1: n_state = ST_DTERM2;
            ST_DTERM2: n_state = ST_DRIVE;
            ST_DRIVE:  n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_GDT;
            ST_GDT:    n_state = ST_VEL;
            ST_VEL:    n_state = ST_QEST;
            ST_QEST:   n_state = ST_POSN;
            ST_POSN:   n_state = ST_QCHK;
            ST_QCHK:   n_state = ST_POS;
            ST_POS:    n_state = ST_OFS;
            ST_OFS:    n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= '0;
            r_half     <= 31'd65536;
            r_inv_half <= 31'd65536;
            r_gain     <= 32'sd65536;
            r_offset   <= '0;
            r_dt       <= 31'd655;
            r_inv_dt   <= 31'd6553600;
            r_delay    <= 4'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                spm_pkg::CFG_CENTER:   r_center   <= $signed(i_cfg_wdata);
                spm_pkg::CFG_HALF:     r_half     <= i_cfg_wdata[30:0];
                spm_pkg::CFG_INV_HALF: r_inv_half <= i_cfg_wdata[30:0];
                spm_pkg::CFG_GAIN:     r_gain     <= $signed(i_cfg_wdata);
                spm_pkg::CFG_OFFSET:   r_offset   <= $signed(i_cfg_wdata);
                spm_pkg::CFG_DT:       r_dt       <= i_cfg_wdata[30:0];
                spm_pkg::CFG_INV_DT:   r_inv_dt   <= i_cfg_wdata[30:0];
                spm_pkg::CFG_DELAY:    r_delay    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_vel       <= '0;
            r_prev      <= '0;
            r_wi        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_cmd <= $signed(s_axis_tdata);
                        if (s_axis_tuser[0]) begin
                            r_pos  <= $signed(s_axis_tdata);
                            r_vel  <= '0;
                            r_prev <= '0;
                            r_wi   <= '0;
                            r_fill <= '0;
                            r_cur  <= '0;
                        end else begin
                            r_wi   <= wi_new;
                            r_fill <= fill_new;
                            r_fwd  <= (idx_c == '0);
                        end
                    end
                end
                ST_NCMD:   r_curn <= prod_q;
                ST_ERR:    r_err  <= spm_pkg::sat33(spm_pkg::sub33(prod_q, r_curn));
                ST_PTERM:  r_diff <= spm_pkg::sat33(spm_pkg::sub33(r_err, r_prev));
                ST_DTERM1: r_p    <= prod_q;
                ST_DRIVE:  r_u    <= spm_pkg::clamp33(spm_pkg::add33(r_p, prod_q),
                                                      spm_pkg::U_SAT);
                ST_GAIN:   r_mag  <= r_u[31] ? 24'(-r_u) : r_u[23:0];
                ST_VEL:    r_vel  <= spm_pkg::clamp33(spm_pkg::add33(r_vel, prod_q),
                                                      spm_pkg::V_SAT);
                ST_QEST:   r_q    <= prod[CUR_SHIFT_HI:spm_pkg::CUR_SHIFT];
                ST_POSN:   r_curn <= spm_pkg::sat33(spm_pkg::add33(r_curn, prod_q));
                ST_QCHK:   r_cur  <= (rem >= 44'(spm_pkg::U_SAT)) ? r_q + 1'b1 : r_q;
                ST_POS: begin
                    r_pos  <= spm_pkg::sat33(spm_pkg::add33(prod_q, r_center));
                    r_prev <= r_err;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos <= spm_pkg::sat33(spm_pkg::add33(r_pos, prod_q));
            r_out_cur <= r_cur;
        end
    end

    a_vel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vel <= spm_pkg::V_SAT) && (r_vel >= -spm_pkg::V_SAT))
        else $error("velocity left its clamp range");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cur <= spm_pkg::CUR_MAX))
        else $error("supply current above full scale");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DELAY_DEPTH))
        else $error("delay line fill count above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after an accepted beat");

endmodule
